// ----- src/lprc_pkg.sv -----
// ---------------------------------------------------------------------------
// lprc_pkg
// Shared types and constants for the longest prefix route counter.
// ---------------------------------------------------------------------------
package lprc_pkg;

    localparam int ADDR_BITS = 32;
    localparam int OPC_W     = 2;
    localparam int IDX_W     = 6;
    localparam int LEN_W     = 6;
    localparam int LINK_W    = 5;
    localparam int RC_W      = 7;

    localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPC_W-1:0] OP_ROUTE = 2'd1;
    localparam logic [OPC_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] prefix;
        logic [LEN_W-1:0]     len;
        logic [LINK_W-1:0]    link;
    } route_entry_t;

endpackage

// ----- src/longest_prefix_route_counter.sv -----
// Steps: a write, an unused opcode or a read past LINKS goes to the output stage;
// a counter read reads the counter RAM; a lookup scans route table entries 0 to
// min(route_count, ROUTES) - 1, one per cycle, then updates the chosen link's counter.
// Throughput: one word at a time; the next word is taken the cycle after the previous
// one reaches the output register.
// Reset: counters read as zero and route_count is 0; the route table is undefined.
// ---------------------------------------------------------------------------
// longest_prefix_route_counter
// IPv4 longest prefix match over a RAM route table with per-link counters.
// ---------------------------------------------------------------------------
module longest_prefix_route_counter #(
    parameter int ROUTES = 64,
    parameter int LINKS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lprc_pkg::RC_W-1:0]          cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lprc_pkg::OPC_W-1:0]         opcode,
    input  logic [lprc_pkg::IDX_W-1:0]         entry_index,
    input  logic [lprc_pkg::ADDR_BITS-1:0]     route_prefix,
    input  logic [lprc_pkg::LEN_W-1:0]         prefix_length,
    input  logic [lprc_pkg::LINK_W-1:0]        link_number,
    input  logic [lprc_pkg::ADDR_BITS-1:0]     packet_address,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lprc_pkg::LINK_W-1:0]        chosen_link,
    output logic [lprc_pkg::ADDR_BITS-1:0]     link_count
);

    import lprc_pkg::*;

    localparam int AW   = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CNTW = $clog2(ROUTES + 1);
    localparam int CW   = $clog2(LINKS + 1);
    localparam int EW   = $bits(route_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CNT_RD,
        S_CNT_WR,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [RC_W-1:0]        route_count_reg;
    logic [OPC_W-1:0]       op_reg, op_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [CNTW-1:0]        n_reg, n_next;
    logic [CNTW-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                   pend_reg, pend_next;
    logic [LEN_W-1:0]       best_len_reg, best_len_next;
    logic [LINK_W-1:0]      best_link_reg, best_link_next;
    logic [CW-1:0]          cnt_idx_reg, cnt_idx_next;
    logic [LINK_W-1:0]      res_link_reg, res_link_next;
    logic [ADDR_BITS-1:0]   res_count_reg, res_count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LINK_W-1:0]      chosen_reg, chosen_next;
    logic [ADDR_BITS-1:0]   count_reg, count_next;
    logic [LINKS:0]         cvalid_reg;

    // route table
    logic                   route_we;
    logic [AW-1:0]          route_waddr;
    route_entry_t           route_wdata;
    logic                   route_re;
    logic [EW-1:0]          route_rdata;
    route_entry_t           entry;

    // counters
    logic                   cnt_we;
    logic                   cnt_re;
    logic [ADDR_BITS-1:0]   cnt_rdata;
    logic [ADDR_BITS-1:0]   cnt_wdata;
    logic [ADDR_BITS-1:0]   cnt_cur;

    logic [31:0]            entry32;
    logic [31:0]            rd_link32;
    logic [31:0]            ch32;
    logic [LINK_W-1:0]      chosen_clamp;
    logic [LINK_W-1:0]      wr_link_clamp;
    logic [LEN_W-1:0]       len_eff;
    logic [ADDR_BITS-1:0]   mask;
    logic                   hit;

    assign entry32      = 32'(entry_index);
    assign rd_link32    = 32'(link_number);
    assign route_waddr  = entry32[AW-1:0];

    assign wr_link_clamp = (32'(link_number) > LINKS) ? LINK_W'(LINKS) : link_number;
    assign chosen_clamp  = (32'(best_link_reg) > LINKS) ? LINK_W'(LINKS) : best_link_reg;
    assign ch32          = 32'(chosen_clamp);

    assign route_wdata.prefix = route_prefix;
    assign route_wdata.len    = prefix_length;
    assign route_wdata.link   = wr_link_clamp;

    assign entry   = route_entry_t'(route_rdata);
    // lengths above 32 act as 32
    assign len_eff = (entry.len > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS) : entry.len;
    assign mask    = (len_eff == '0) ? '0
                   : ({ADDR_BITS{1'b1}} << (LEN_W'(ADDR_BITS) - len_eff));
    assign hit     = ((addr_reg & mask) == (entry.prefix & mask)) && (len_eff > best_len_reg);

    assign cnt_cur   = cvalid_reg[cnt_idx_reg] ? cnt_rdata : '0;
    // saturate at all ones
    assign cnt_wdata = (cnt_cur == {ADDR_BITS{1'b1}}) ? cnt_cur : cnt_cur + 1'b1;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign chosen_link = chosen_reg;
    assign link_count  = count_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        n_next         = n_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = pend_reg;
        best_len_next  = best_len_reg;
        best_link_next = best_link_reg;
        cnt_idx_next   = cnt_idx_reg;
        res_link_next  = res_link_reg;
        res_count_next = res_count_reg;
        out_valid_next = out_valid_reg;
        chosen_next    = chosen_reg;
        count_next     = count_reg;
        route_we       = 1'b0;
        route_re       = 1'b0;
        cnt_we         = 1'b0;
        cnt_re         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = opcode;
                    addr_next      = packet_address;
                    res_link_next  = '0;
                    res_count_next = '0;
                    case (opcode)
                        OP_WRITE:
                        begin
                            route_we   = (entry32 < ROUTES);
                            state_next = S_DONE;
                        end
                        OP_ROUTE:
                        begin
                            n_next = (32'(route_count_reg) > ROUTES) ? CNTW'(ROUTES)
                                                                     : CNTW'(route_count_reg);
                            scan_cnt_next  = '0;
                            pend_next      = 1'b0;
                            best_len_next  = '0;
                            best_link_next = '0;
                            state_next     = S_SCAN;
                        end
                        OP_READ:
                        begin
                            if (rd_link32 <= LINKS)
                            begin
                                cnt_idx_next = rd_link32[CW-1:0];
                                state_next   = S_CNT_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // compare the entry read last cycle, issue the next read
                if (pend_reg && hit)
                begin
                    best_len_next  = len_eff;
                    best_link_next = entry.link;
                end
                if (scan_cnt_reg < n_reg)
                begin
                    route_re      = 1'b1;
                    scan_cnt_next = CNTW'(scan_cnt_reg + 1'b1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && (scan_cnt_reg == n_reg))
                begin
                    cnt_idx_next = ch32[CW-1:0];
                    state_next   = S_CNT_RD;
                end
            end
            S_CNT_RD:
            begin
                cnt_re     = 1'b1;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                if (op_reg == OP_ROUTE)
                begin
                    cnt_we         = 1'b1;
                    res_link_next  = chosen_clamp;
                    res_count_next = cnt_wdata;
                end
                else
                begin
                    res_link_next  = '0;
                    res_count_next = cnt_cur;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    chosen_next    = res_link_reg;
                    count_next     = res_count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            route_count_reg <= '0;
            op_reg          <= '0;
            addr_reg        <= '0;
            n_reg           <= '0;
            scan_cnt_reg    <= '0;
            pend_reg        <= 1'b0;
            best_len_reg    <= '0;
            best_link_reg   <= '0;
            cnt_idx_reg     <= '0;
            res_link_reg    <= '0;
            res_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
            chosen_reg      <= '0;
            count_reg       <= '0;
            cvalid_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            n_reg         <= n_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            best_len_reg  <= best_len_next;
            best_link_reg <= best_link_next;
            cnt_idx_reg   <= cnt_idx_next;
            res_link_reg  <= res_link_next;
            res_count_reg <= res_count_next;
            out_valid_reg <= out_valid_next;
            chosen_reg    <= chosen_next;
            count_reg     <= count_next;
            if (cfg_wr_en)
            begin
                route_count_reg <= cfg_wr_data;
            end
            if (cnt_we)
            begin
                cvalid_reg[cnt_idx_reg] <= 1'b1;
            end
        end
    end

    lprc_ram #(
        .WIDTH (EW),
        .DEPTH (ROUTES)
    ) u_route_ram (
        .clk   (clk),
        .we    (route_we),
        .waddr (route_waddr),
        .wdata (route_wdata),
        .re    (route_re),
        .raddr (scan_cnt_reg[AW-1:0]),
        .rdata (route_rdata)
    );

    lprc_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (LINKS + 1)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_idx_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_idx_reg),
        .rdata (cnt_rdata)
    );

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_cnt_reg <= n_reg))
        else $error("scan ran past the active route count");

    a_cnt_write_op: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> ((state_reg == S_CNT_WR) && (op_reg == OP_ROUTE)))
        else $error("counter written outside a route update");

    a_cnt_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CNT_RD) |-> (32'(cnt_idx_reg) <= LINKS))
        else $error("counter index beyond last link");

    a_out_link_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(chosen_reg) <= LINKS))
        else $error("chosen link beyond last link");

    a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
        route_re |=> pend_reg)
        else $error("route read issued without a pending compare");
`endif

endmodule

// ----- src/lprc_ram.sv -----
// ---------------------------------------------------------------------------
// lprc_ram
// Single-port-write, single-port-read RAM with a registered read.
// ---------------------------------------------------------------------------
module lprc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/lprc_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lprc_checker
// Watches the input, output and configuration ports of the route counter.
// Keeps its own copy of the route table, the per-link counters and
// route_count, predicts the word each accepted input word produces, and
// compares every output word field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module lprc_checker #(
    parameter int ROUTES = 64,
    parameter int LINKS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lprc_pkg::RC_W-1:0]      cfg_wr_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [lprc_pkg::OPC_W-1:0]     opcode,
    input  logic [lprc_pkg::IDX_W-1:0]     entry_index,
    input  logic [lprc_pkg::ADDR_BITS-1:0] route_prefix,
    input  logic [lprc_pkg::LEN_W-1:0]     prefix_length,
    input  logic [lprc_pkg::LINK_W-1:0]    link_number,
    input  logic [lprc_pkg::ADDR_BITS-1:0] packet_address,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [lprc_pkg::LINK_W-1:0]    chosen_link,
    input  logic [lprc_pkg::ADDR_BITS-1:0] link_count,
    output int                             fail_count,
    output int                             outstanding
);

    import lprc_pkg::*;

    typedef struct packed {
        logic [LINK_W-1:0]    link;
        logic [ADDR_BITS-1:0] count;
    } link_word_t;

    route_entry_t         route_tbl [ROUTES];
    logic [ADDR_BITS-1:0] link_hits [LINKS+1];
    logic [RC_W-1:0]      scan_count;
    link_word_t           due_words [$];

    function automatic logic [LINK_W-1:0] longest_match(input logic [ADDR_BITS-1:0] addr);
        int                   n;
        int                   best_len;
        int                   eff;
        logic [LINK_W-1:0]    best;
        logic [ADDR_BITS-1:0] m;
        n        = (scan_count > ROUTES) ? ROUTES : int'(scan_count);
        best_len = 0;
        best     = '0;
        for (int i = 0; i < n; i++)
        begin
            // lengths above 32 act as 32
            eff = (route_tbl[i].len > ADDR_BITS) ? ADDR_BITS : int'(route_tbl[i].len);
            m   = (eff == 0) ? '0 : ({ADDR_BITS{1'b1}} << (ADDR_BITS - eff));
            if (((addr & m) == (route_tbl[i].prefix & m)) && (eff > best_len))
            begin
                best_len = eff;
                best     = route_tbl[i].link;
            end
        end
        return best;
    endfunction

    function automatic link_word_t predict_word(
        input logic [OPC_W-1:0]     op,
        input logic [IDX_W-1:0]     idx,
        input logic [ADDR_BITS-1:0] pfx,
        input logic [LEN_W-1:0]     len,
        input logic [LINK_W-1:0]    lnk,
        input logic [ADDR_BITS-1:0] addr
    );
        link_word_t        w;
        logic [LINK_W-1:0] c;
        w = '0;
        case (op)
            OP_WRITE:
            begin
                if (idx < ROUTES)
                begin
                    route_tbl[idx].prefix = pfx;
                    route_tbl[idx].len    = len;
                    route_tbl[idx].link   = (lnk > LINKS) ? LINK_W'(LINKS) : lnk;
                end
            end
            OP_ROUTE:
            begin
                c = longest_match(addr);
                // saturate at all ones
                if (link_hits[c] != '1)
                    link_hits[c] = link_hits[c] + 1'b1;
                w.link  = c;
                w.count = link_hits[c];
            end
            OP_READ:
            begin
                if (lnk <= LINKS)
                    w.count = link_hits[lnk];
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        link_word_t got;
        link_word_t want;
        if (!rst_n)
        begin
            due_words.delete();
            for (int i = 0; i <= LINKS; i++)
                link_hits[i] = '0;
            scan_count  = '0;
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            // retire first: a word leaving now always belongs to an older input
            if (out_valid && !out_stall)
            begin
                got.link  = chosen_link;
                got.count = link_count;
                if (due_words.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, actual %0d / %0d",
                             $time, got.link, got.count);
                    fail_count++;
                end
                else
                begin
                    want = due_words.pop_front();
                    if (got.link !== want.link)
                    begin
                        $display("%0t chosen_link mismatch: expected %0d actual %0d",
                                 $time, want.link, got.link);
                        fail_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t link_count mismatch: expected %0d actual %0d",
                                 $time, want.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
                scan_count = cfg_wr_data;
            if (in_valid && !in_stall)
                due_words.push_back(predict_word(opcode, entry_index, route_prefix,
                                                 prefix_length, link_number, packet_address));
            outstanding <= due_words.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the longest prefix route counter: a directed pass over the
// table corner cases, then random phases at many route_count settings with
// nested prefixes and addresses aimed at stored routes. Both channels idle
// at random; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;
    import lprc_pkg::*;

    localparam int ROUTES      = 64;
    localparam int LINKS       = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 100;
    localparam int LONG_HOLD   = 500;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 155;

    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [RC_W-1:0]      cfg_wr_data    = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [OPC_W-1:0]     opcode         = '0;
    logic [IDX_W-1:0]     entry_index    = '0;
    logic [ADDR_BITS-1:0] route_prefix   = '0;
    logic [LEN_W-1:0]     prefix_length  = '0;
    logic [LINK_W-1:0]    link_number    = '0;
    logic [ADDR_BITS-1:0] packet_address = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic [LINK_W-1:0]    chosen_link;
    logic [ADDR_BITS-1:0] link_count;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;

    bit gaps_on  = 1'b1;
    bit hold_req = 1'b0;

    // mirror of what has been written, used to aim lookups
    bit                   written  [ROUTES];
    logic [ADDR_BITS-1:0] slot_pfx [ROUTES];
    logic [LEN_W-1:0]     slot_len [ROUTES];
    logic [ADDR_BITS-1:0] base_pool [4];
    int                   cur_rc = 0;
    int                   rc_plan [PHASES] = '{64, 3, 127, 0, 1, 17, 65, 100, 40, 9, 64, 2};

    int n_writes = 0;
    int n_routes = 0;
    int n_reads  = 0;
    int n_unused = 0;

    longest_prefix_route_counter #(
        .ROUTES (ROUTES),
        .LINKS  (LINKS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .route_prefix   (route_prefix),
        .prefix_length  (prefix_length),
        .link_number    (link_number),
        .packet_address (packet_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chosen_link    (chosen_link),
        .link_count     (link_count)
    );

    lprc_checker #(
        .ROUTES (ROUTES),
        .LINKS  (LINKS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .route_prefix   (route_prefix),
        .prefix_length  (prefix_length),
        .link_number    (link_number),
        .packet_address (packet_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chosen_link    (chosen_link),
        .link_count     (link_count),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [ADDR_BITS-1:0] net_mask(input logic [LEN_W-1:0] len);
        int eff;
        eff = (len > ADDR_BITS) ? ADDR_BITS : int'(len);
        return (eff == 0) ? '0 : ({ADDR_BITS{1'b1}} << (ADDR_BITS - eff));
    endfunction

    function automatic logic [LINK_W-1:0] pick_link();
        if ($urandom_range(0, 99) < 85)
            return LINK_W'($urandom_range(0, LINKS));
        return LINK_W'($urandom_range(LINKS + 1, 31));
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        if ($urandom_range(0, 99) < 80)
            return LEN_W'($urandom_range(0, ADDR_BITS));
        return LEN_W'($urandom_range(ADDR_BITS + 1, 63));
    endfunction

    // offer one word and hold it until taken
    task automatic send_word(
        input logic [OPC_W-1:0]     op,
        input logic [IDX_W-1:0]     idx,
        input logic [ADDR_BITS-1:0] pfx,
        input logic [LEN_W-1:0]     len,
        input logic [LINK_W-1:0]    lnk,
        input logic [ADDR_BITS-1:0] addr
    );
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        entry_index    <= idx;
        route_prefix   <= pfx;
        prefix_length  <= len;
        link_number    <= lnk;
        packet_address <= addr;
        do
            @(posedge clk);
        while (in_stall);
        case (op)
            OP_WRITE:
            begin
                n_writes++;
                written[idx]  = 1'b1;
                slot_pfx[idx] = pfx;
                slot_len[idx] = len;
            end
            OP_ROUTE: n_routes++;
            OP_READ:  n_reads++;
            default:  n_unused++;
        endcase
    endtask

    task automatic write_slot(input int idx);
        logic [LEN_W-1:0]     len;
        logic [ADDR_BITS-1:0] m;
        logic [ADDR_BITS-1:0] pfx;
        len = pick_len();
        m   = net_mask(len);
        // network bits from a shared base so routes nest; host bits are noise
        pfx = (base_pool[$urandom_range(0, 3)] & m) | ($urandom & ~m);
        send_word(OP_WRITE, IDX_W'(idx), pfx, len, pick_link(), $urandom);
    endtask

    // drain, then write route_count while the block is idle
    task automatic set_route_count(input int rc);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= RC_W'(rc);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_rc = rc;
    endtask

    // every slot a lookup can scan must hold a route
    task automatic fill_table(input int rc);
        int n;
        n = (rc > ROUTES) ? ROUTES : rc;
        for (int i = 0; i < n; i++)
        begin
            if (!written[i])
                write_slot(i);
        end
    endtask

    task automatic random_word();
        int                   r;
        int                   n;
        int                   j;
        logic [ADDR_BITS-1:0] m;
        logic [ADDR_BITS-1:0] addr;
        r = $urandom_range(0, 99);
        n = (cur_rc > ROUTES) ? ROUTES : cur_rc;
        if (r < 25)
            write_slot($urandom_range(0, ROUTES - 1));
        else if (r < 80)
        begin
            if ((n > 0) && ($urandom_range(0, 3) != 0))
            begin
                j    = $urandom_range(0, n - 1);
                m    = net_mask(slot_len[j]);
                addr = (slot_pfx[j] & m) | ($urandom & ~m);
                // near miss: flip one bit
                if ($urandom_range(0, 9) == 0)
                    addr = addr ^ (32'h1 << $urandom_range(0, ADDR_BITS - 1));
            end
            else if ($urandom_range(0, 1) == 1)
                addr = base_pool[$urandom_range(0, 3)] ^ ADDR_BITS'($urandom_range(0, 255));
            else
                addr = $urandom;
            send_word(OP_ROUTE, IDX_W'($urandom), $urandom, LEN_W'($urandom),
                      LINK_W'($urandom), addr);
        end
        else if (r < 95)
            send_word(OP_READ, IDX_W'($urandom), $urandom, LEN_W'($urandom),
                      pick_link(), $urandom);
        else
            send_word(OP_UNUSED, IDX_W'($urandom), $urandom, LEN_W'($urandom),
                      LINK_W'($urandom), $urandom);
    endtask

    // output side: random stall per word, one long hold-off on request
    initial
    begin
        int  hold;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = 0;
            if (hold_req && !held)
            begin
                hold = LONG_HOLD;
                held = 1'b1;
            end
            else if (gaps_on)
                hold = $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL longest_prefix_route_counter");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < ROUTES; i++)
            written[i] = 1'b0;
        base_pool[0] = $urandom;
        base_pool[1] = base_pool[0] ^ ADDR_BITS'($urandom_range(0, 65535));
        base_pool[2] = $urandom;
        base_pool[3] = 32'h0A00_0000 | ADDR_BITS'($urandom_range(0, 24'hFF_FFFF));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty scan range: no match, link 0
        send_word(OP_ROUTE, '0, '0, '0, '0, 32'h0000_0000);
        send_word(OP_READ, '1, '1, '1, 5'd0, '1);
        // zero-length route, nested /16 and /24, a tie, long prefix, big link
        send_word(OP_WRITE, 6'd0, 32'h0000_0000, 6'd0, 5'd5, '0);
        send_word(OP_WRITE, 6'd1, 32'hC0A8_0000, 6'd16, 5'd3, '0);
        send_word(OP_WRITE, 6'd2, 32'hC0A8_0100, 6'd24, 5'd7, '0);
        send_word(OP_WRITE, 6'd3, 32'hC0A8_01FF, 6'd24, 5'd9, '0);
        send_word(OP_WRITE, 6'd4, 32'h0A00_0000, 6'd40, 5'd20, '0);
        send_word(OP_WRITE, 6'd5, 32'hFFFF_FFFF, 6'd32, 5'd16, '0);
        send_word(OP_WRITE, 6'd6, 32'h8000_0000, 6'd1, 5'd1, '0);
        send_word(OP_WRITE, 6'd63, 32'hFFFF_FFFF, 6'd63, 5'd31, '1);
        set_route_count(7);
        send_word(OP_ROUTE, '0, '0, '0, '0, 32'hC0A8_0105);
        send_word(OP_ROUTE, '0, '0, '0, '0, 32'hC0A8_FF01);
        send_word(OP_ROUTE, '0, '0, '0, '0, 32'h0A00_0000);
        send_word(OP_ROUTE, '0, '0, '0, '0, 32'h0A00_0001);
        send_word(OP_ROUTE, '1, '1, '1, '1, 32'hFFFF_FFFF);
        send_word(OP_ROUTE, '0, '0, '0, '0, 32'h0000_0000);
        send_word(OP_ROUTE, '0, '0, '0, '0, 32'h8000_0001);
        send_word(OP_READ, '0, '0, '0, 5'd16, '0);
        send_word(OP_READ, '0, '0, '0, 5'd17, '0);
        send_word(OP_READ, '0, '0, '0, 5'd31, '0);
        send_word(OP_READ, '0, '0, '0, 5'd7, '0);
        send_word(OP_UNUSED, '1, '1, '1, '1, '1);
        set_route_count(1);
        send_word(OP_ROUTE, '0, '0, '0, '0, 32'hC0A8_0105);
        send_word(OP_READ, '0, '0, '0, 5'd0, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            set_route_count(rc_plan[p]);
            fill_table(rc_plan[p]);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (k % 32 == 0)
                    gaps_on = ($urandom_range(0, 3) != 0);
                // back up the output while input words keep coming
                if ((p == 1) && (k == 40))
                    hold_req <= 1'b1;
                random_word();
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d table writes, %0d lookups, %0d counter reads, %0d unused-opcode words",
                 n_writes, n_routes, n_reads, n_unused);
        $display("over %0d route_count settings from 0 to 127, with random idling and a long hold-off",
                 PHASES + 2);
        if (fail_count == 0)
            $display("PASS longest_prefix_route_counter");
        else
            $display("FAIL longest_prefix_route_counter");
        $finish;
    end

endmodule
